@@ rtl/u8d_pkg.sv @@
package u8d_pkg;

	localparam int unsigned CP_W   = 21;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CNT_W  = 2;

	localparam logic [CP_W-1:0] REPL_CHAR = 21'h00003F;
	localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

	typedef logic [2:0] len_t;

	localparam len_t LEN_BAD = 3'd0;
	localparam len_t LEN_1   = 3'd1;
	localparam len_t LEN_2   = 3'd2;
	localparam len_t LEN_3   = 3'd3;
	localparam len_t LEN_4   = 3'd4;

	typedef struct packed {
		logic            emit;
		logic            subst;
		logic [CP_W-1:0] cp;
	} dec_res_t;

	function automatic len_t lead_len(input logic [BYTE_W-1:0] lead);
		len_t l;
		if (lead[7] == 1'b0) l = LEN_1;
		else if (lead[7:5] == 3'b110) l = LEN_2;
		else if (lead[7:4] == 4'b1110) l = LEN_3;
		else if (lead[7:3] == 5'b11110) l = LEN_4;
		else l = LEN_BAD;
		return l;
	endfunction

	function automatic logic is_cont(input logic [BYTE_W-1:0] b);
		return b[7:6] == 2'b10;
	endfunction

endpackage

@@ rtl/u8d_ifs.sv @@
interface u8d_byte_if;
	import u8d_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_req;

	modport source (output valid, output byte_req, input ready);
	modport sink (input valid, input byte_req, output ready);
endinterface

interface u8d_cp_if;
	import u8d_pkg::*;
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;
	logic            substituted;

	modport source (output valid, output code_point, output substituted, input ready);
	modport sink (input valid, input code_point, input substituted, output ready);
endinterface

@@ rtl/u8d_decode.sv @@
module u8d_decode
	import u8d_pkg::*;
(
	input  logic [BYTE_W-1:0]        b,
	input  logic [CNT_W-1:0]         count,
	input  logic [2:0][BYTE_W-1:0]   held,
	output dec_res_t                 res
);

	logic [BYTE_W-1:0] lead;
	len_t              len;
	logic [CP_W-1:0]   cp;
	logic              bad;
	len_t              cnt_next;

	always_comb begin
		lead     = (count == '0) ? b : held[0];
		len      = lead_len(lead);
		cnt_next = len_t'({1'b0, count}) + len_t'(1);
		cp       = '0;
		bad      = 1'b0;
		case (len)
			LEN_1: begin
				cp = {13'b0, lead};
			end
			LEN_2: begin
				cp  = {10'b0, lead[4:0], b[5:0]};
				bad = !is_cont(b) || (lead[4:1] == 4'b0);
			end
			LEN_3: begin
				cp  = {5'b0, lead[3:0], held[1][5:0], b[5:0]};
				bad = !is_cont(held[1]) || !is_cont(b) || (cp[15:11] == 5'b0);
			end
			LEN_4: begin
				cp  = {lead[2:0], held[1][5:0], held[2][5:0], b[5:0]};
				bad = !is_cont(held[1]) || !is_cont(held[2]) || !is_cont(b)
					|| (cp[20:16] == 5'b0) || (cp > CP_MAX);
			end
			default: begin
				bad = 1'b1;
			end
		endcase
		res.emit  = (len == LEN_BAD) || (cnt_next == len);
		res.subst = bad;
		res.cp    = bad ? REPL_CHAR : cp;
	end

endmodule

@@ rtl/utf8_stream_decoder.sv @@
// Channel   Dir  Payload                       Transaction
// byte_in   in   byte_req[7:0]                 valid && ready
// cp_out    out  code_point[20:0], substituted valid && ready
//
// One byte per cycle sustained while cp_out is not stalled; the result of a
// completing byte passes the input register, then the result register, to cp_out.
// The decode of one byte against the held sequence is a single pass of logic
// between the input register and the result register.
// Reset clears the valid flags and the held byte count; held bytes are not reset.
// A stalled cp_out holds its result; byte_in keeps accepting while the input
// register can still move or is empty.
module utf8_stream_decoder
	import u8d_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	u8d_byte_if.sink   byte_in,
	u8d_cp_if.source   cp_out
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic [CNT_W-1:0]       count_q;
	logic [2:0][BYTE_W-1:0] held_q;

	logic            out_valid_q;
	logic [CP_W-1:0] out_cp_q;
	logic            out_subst_q;

	logic     out_free;
	logic     adv_s1;
	dec_res_t res;

	assign out_free     = !out_valid_q || cp_out.ready;
	assign adv_s1       = valid_s1 && out_free;
	assign byte_in.ready = !valid_s1 || out_free;

	u8d_decode u_decode (
		.b     (byte_s1),
		.count (count_q),
		.held  (held_q),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			byte_s1 <= byte_in.byte_req;
		end
	end

	// advance the held sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (adv_s1) begin
			count_q <= res.emit ? '0 : count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && !res.emit) begin
			case (count_q)
				2'd0:    held_q[0] <= byte_s1;
				2'd1:    held_q[1] <= byte_s1;
				2'd2:    held_q[2] <= byte_s1;
				default: held_q[0] <= held_q[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.emit) begin
			out_cp_q    <= res.cp;
			out_subst_q <= res.subst;
		end
	end

	assign cp_out.valid       = out_valid_q;
	assign cp_out.code_point  = out_cp_q;
	assign cp_out.substituted = out_subst_q;

	a_subst_is_repl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_subst_q |-> out_cp_q == REPL_CHAR)
		else $error("substituted result without replacement character");

	a_held_lead_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> lead_len(held_q[0]) > len_t'({1'b0, count_q}))
		else $error("held count not below lead length");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res.emit |=> count_q == '0 && out_valid_q)
		else $error("emitted result did not clear count or load output");

	a_no_adv_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(count_q) && $stable(byte_s1))
		else $error("input stage moved while output stalled");

endmodule

@@ tb/utf8_decode_checker.sv @@
module utf8_decode_checker
	import u8d_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	u8d_byte_if  byte_mon,
	u8d_cp_if    cp_mon,
	output int   mismatches,
	output int   cps_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic            subst;
		logic [CP_W-1:0] cp;
	} cp_expect_t;

	cp_expect_t        expected_cps[$];
	logic [BYTE_W-1:0] seq_bytes [4];
	int unsigned       seq_held;

	function automatic len_t announced_len(input logic [BYTE_W-1:0] lead);
		if (lead < 8'h80) return LEN_1;
		if ((lead & 8'hE0) == 8'hC0) return LEN_2;
		if ((lead & 8'hF0) == 8'hE0) return LEN_3;
		if ((lead & 8'hF8) == 8'hF0) return LEN_4;
		return LEN_BAD;
	endfunction

	task automatic decode_byte(input logic [BYTE_W-1:0] b);
		len_t            n;
		logic [CP_W-1:0] cp;
		logic            bad;
		int              i;
		seq_bytes[seq_held] = b;
		seq_held++;
		n = announced_len(seq_bytes[0]);
		if (n == LEN_BAD) begin
			expected_cps.push_back('{subst: 1'b1, cp: REPL_CHAR});
			seq_held = 0;
			return;
		end
		if (seq_held < n)
			return;
		case (n)
			LEN_1: begin
				cp = CP_W'(seq_bytes[0]);
			end
			LEN_2: begin
				cp = CP_W'(seq_bytes[0][4:0]);
			end
			LEN_3: begin
				cp = CP_W'(seq_bytes[0][3:0]);
			end
			default: begin
				cp = CP_W'(seq_bytes[0][2:0]);
			end
		endcase
		bad = 1'b0;
		for (i = 1; i < n; i++) begin
			if (seq_bytes[i][7:6] != 2'b10)
				bad = 1'b1;
			cp = {cp[CP_W-7:0], seq_bytes[i][5:0]};
		end
		if (n == LEN_2 && cp <= 21'h00007F)
			bad = 1'b1;
		if (n == LEN_3 && cp <= 21'h0007FF)
			bad = 1'b1;
		if (n == LEN_4 && (cp <= 21'h00FFFF || cp > CP_MAX))
			bad = 1'b1;
		if (bad)
			expected_cps.push_back('{subst: 1'b1, cp: REPL_CHAR});
		else
			expected_cps.push_back('{subst: 1'b0, cp: cp});
		seq_held = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cp_expect_t want;
		if (!arst_n) begin
			mismatches = 0;
			seq_held = 0;
			expected_cps.delete();
		end else begin
			if (cp_mon.valid && cp_mon.ready) begin
				if (expected_cps.size() == 0) begin
					$error("unexpected transaction: code_point %h substituted %b",
						cp_mon.code_point, cp_mon.substituted);
					mismatches++;
				end else begin
					want = expected_cps.pop_front();
					if (cp_mon.code_point !== want.cp) begin
						$error("code_point: expected %h actual %h",
							want.cp, cp_mon.code_point);
						mismatches++;
					end
					if (cp_mon.substituted !== want.subst) begin
						$error("substituted: expected %b actual %b",
							want.subst, cp_mon.substituted);
						mismatches++;
					end
				end
			end
			if (byte_mon.valid && byte_mon.ready)
				decode_byte(byte_mon.byte_req);
		end
		cps_due = expected_cps.size();
	end

endmodule

@@ tb/tb_utf8_stream_decoder.sv @@
module tb_utf8_stream_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import u8d_pkg::*;

	localparam int ITEM_TARGET   = 700;
	localparam int LONG_STALL    = 400;
	localparam int DRAIN_CYCLES  = 8;
	localparam int TIME_LIMIT_NS = 2_000_000;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   cps_due;
	int   sent = 0;
	int   send_idle = 0;
	int   recv_idle = 0;
	int   stall_asked = 0;
	int   stall_served = 0;

	logic [BYTE_W-1:0] directed_bytes [25] = '{
		8'h00, 8'h3F, 8'h7F,
		8'hC2, 8'h80,
		8'hC0, 8'h80,
		8'hE0, 8'h9F, 8'hBF,
		8'hED, 8'hA0, 8'h80,
		8'hF4, 8'h8F, 8'hBF, 8'hBF,
		8'hF4, 8'h90, 8'h80, 8'h80,
		8'h80, 8'hFF,
		8'hC3, 8'h41
	};

	u8d_byte_if byte_ch ();
	u8d_cp_if   cp_ch ();

	utf8_stream_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_in(byte_ch),
		.cp_out (cp_ch)
	);

	utf8_decode_checker decode_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_mon  (byte_ch),
		.cp_mon    (cp_ch),
		.mismatches(mismatches),
		.cps_due   (cps_due)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#(TIME_LIMIT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		cp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_served < stall_asked) begin
				stall_served++;
				cp_ch.ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
			end
			cp_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid    <= 1'b1;
		byte_ch.byte_req <= b;
		do @(posedge clk); while (!byte_ch.ready);
		sent++;
	endtask

	task automatic send_random_seq();
		logic [BYTE_W-1:0] seq [4];
		logic [BYTE_W-1:0] lead_mark;
		logic [CP_W-1:0]   cp;
		int                r, n, m, k;
		r = $urandom_range(99);
		n = 1;
		m = 1;
		if (r < 20) begin
			seq[0] = BYTE_W'($urandom_range(8'h7F));
		end else if (r < 30) begin
			seq[0] = BYTE_W'($urandom_range(8'hFF));
		end else begin
			n = $urandom_range(4, 2);
			m = n;
			lead_mark = 8'hFF << (8 - n);
			if (r < 90) begin
				case (n)
					2: cp = CP_W'($urandom_range(21'h0007FF, 21'h000080));
					3: cp = CP_W'($urandom_range(21'h00FFFF, 21'h000800));
					default: cp = CP_W'($urandom_range(21'h10FFFF, 21'h010000));
				endcase
				for (k = n - 1; k > 0; k--) begin
					seq[k] = {2'b10, cp[5:0]};
					cp = cp >> 6;
				end
				seq[0] = lead_mark | BYTE_W'(cp);
				// corrupt one trailing byte, or cut the sequence short
				if (r >= 75 && r < 83)
					seq[$urandom_range(n - 1, 1)] = BYTE_W'($urandom_range(8'hFF));
				else if (r >= 83)
					m = $urandom_range(n - 1, 1);
			end else begin
				// random payload bits: reaches overlong and out-of-range forms
				seq[0] = lead_mark | (BYTE_W'($urandom) & (8'hFF >> (n + 1)));
				for (k = 1; k < n; k++)
					seq[k] = {2'b10, 6'($urandom)};
			end
		end
		for (k = 0; k < m; k++)
			push_byte(seq[k]);
	endtask

	task automatic drain_results();
		byte_ch.valid <= 1'b0;
		@(negedge clk);
		while (cps_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n           <= 1'b0;
		byte_ch.valid    <= 1'b0;
		byte_ch.byte_req <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i])
			push_byte(directed_bytes[i]);

		send_idle = 25;
		recv_idle = 75;
		while (sent < 250)
			send_random_seq();
		drain_results();

		send_idle = 75;
		recv_idle = 25;
		while (sent < 480)
			send_random_seq();
		drain_results();

		send_idle = 0;
		recv_idle = 0;
		stall_asked++;
		while (sent < ITEM_TARGET)
			send_random_seq();
		drain_results();

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
